// ===== sv/bsab_pkg.sv =====
// Shared constants, register codes and stage types for the sprite blitter.
`default_nettype none
package bsab_pkg;
  localparam int SPRITE_SIDE = 64;
  localparam int TEXEL_DEPTH = SPRITE_SIDE * SPRITE_SIDE;
  localparam int ADDR_W      = $clog2(TEXEL_DEPTH);
  localparam int COORD_W     = $clog2(SPRITE_SIDE);
  localparam int DIM_W       = 7;
  localparam int CANVAS_SIDE = 4096;
  localparam int DIST_W      = 24;
  localparam int PROD_W      = 49;
  localparam int MAC_W       = COORD_W + DIM_W;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_COMPOSITE = 1'b1;

  localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RECT_LEFT     = 3'd2;
  localparam logic [2:0] REG_RECT_TOP      = 3'd3;
  localparam logic [2:0] REG_RECT_WIDTH    = 3'd4;
  localparam logic [2:0] REG_RECT_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_STEP_H        = 3'd6;
  localparam logic [2:0] REG_STEP_V        = 3'd7;

  localparam logic signed [DIST_W-1:0] PIX_ONE  = 24'sd256;
  localparam logic signed [DIST_W-1:0] PIX_HALF = 24'sd128;
  localparam logic signed [PROD_W-1:0] MAP_BIAS = 49'sd8388608;
  localparam logic [23:0] ALPHA_FULL = 24'd16711680;

  typedef struct packed {
    logic [DIM_W-1:0]  sprite_width;
    logic [DIM_W-1:0]  sprite_height;
    logic signed [21:0] rect_left;
    logic signed [21:0] rect_top;
    logic [20:0]       rect_width;
    logic [20:0]       rect_height;
    logic [23:0]       step_horizontal;
    logic [23:0]       step_vertical;
  } bsab_cfg_t;

  typedef struct packed {
    logic       valid;
    logic       composite;
    logic       hit;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bsab_ctl_t;
endpackage
`default_nettype wire

// ===== sv/bsab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/bsab_map.sv =====
// Coverage test and pixel-to-sprite coordinate mapping, stages one to three.
`default_nettype none
module bsab_map (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        take,
  input  wire bsab_pkg::bsab_cfg_t         cfg,
  input  wire logic [bsab_pkg::DIM_W-1:0]  w_sat,
  input  wire logic [bsab_pkg::DIM_W-1:0]  h_sat,
  input  wire logic                        operation,
  input  wire logic [11:0]                 texel_index,
  input  wire logic [31:0]                 texel_rgba,
  input  wire logic [11:0]                 pixel_x,
  input  wire logic [11:0]                 pixel_y,
  input  wire logic [7:0]                  canvas_red,
  input  wire logic [7:0]                  canvas_green,
  input  wire logic [7:0]                  canvas_blue,
  output bsab_pkg::bsab_ctl_t              c3,
  output logic [bsab_pkg::COORD_W-1:0]     x0,
  output logic [bsab_pkg::COORD_W-1:0]     x1,
  output logic [bsab_pkg::COORD_W-1:0]     y0,
  output logic [bsab_pkg::COORD_W-1:0]     y1,
  output logic [7:0]                       fx,
  output logic [7:0]                       fy,
  output logic [11:0]                      idx3,
  output logic [31:0]                      rgba3
);
  import bsab_pkg::*;

  bsab_ctl_t c1, c2, c1_next;
  logic signed [DIST_W-1:0] dx1, dy1, dx_next, dy_next;
  logic signed [PROD_W-1:0] px2, py2;
  logic [11:0] idx1, idx2;
  logic [31:0] rgba1, rgba2;
  logic signed [DIST_W-1:0] pos_x, pos_y, left_e, top_e, right_e, bot_e;
  logic cov_x, cov_y, enable;
  logic [COORD_W+7:0] pick_x, pick_y;
  logic [COORD_W-1:0] x0_next, y0_next, x1_next, y1_next;

  function automatic logic [COORD_W+7:0] map_pick(input logic signed [PROD_W-1:0] p,
                                                  input logic [DIM_W-1:0] dim);
    logic signed [PROD_W-1:0] u;
    logic signed [PROD_W-1:0] hi;
    logic [DIM_W-1:0] dm1;
    dm1 = dim - DIM_W'(1);
    hi  = $signed(PROD_W'({dm1, 24'h000000}));
    u   = p - MAP_BIAS;
    if (u < 0) begin
      u = '0;
    end else if (u > hi) begin
      u = hi;
    end
    return {u[24+COORD_W-1:24], u[23:16]};
  endfunction

  function automatic logic [COORD_W-1:0] next_tap(input logic [COORD_W-1:0] c,
                                                  input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] cp;
    logic [DIM_W-1:0] dm1;
    cp  = DIM_W'(c) + DIM_W'(1);
    dm1 = dim - DIM_W'(1);
    return (cp < dim) ? cp[COORD_W-1:0] : dm1[COORD_W-1:0];
  endfunction

  always_comb begin
    pos_x   = $signed(DIST_W'({pixel_x, 8'h00}));
    pos_y   = $signed(DIST_W'({pixel_y, 8'h00}));
    left_e  = DIST_W'(cfg.rect_left);
    top_e   = DIST_W'(cfg.rect_top);
    right_e = left_e + $signed(DIST_W'(cfg.rect_width));
    bot_e   = top_e + $signed(DIST_W'(cfg.rect_height));
    cov_x   = ({1'b0, pixel_x} < 13'(CANVAS_SIDE)) && (pos_x + PIX_ONE > left_e) &&
              (pos_x < right_e);
    cov_y   = ({1'b0, pixel_y} < 13'(CANVAS_SIDE)) && (pos_y + PIX_ONE > top_e) &&
              (pos_y < bot_e);
    enable  = (w_sat != '0) && (h_sat != '0) && (cfg.rect_width != '0) &&
              (cfg.rect_height != '0);
    dx_next = pos_x + PIX_HALF - left_e;
    dy_next = pos_y + PIX_HALF - top_e;
    c1_next.valid     = take;
    c1_next.composite = operation;
    c1_next.hit       = (operation == OP_COMPOSITE) && enable && cov_x && cov_y;
    c1_next.red       = canvas_red;
    c1_next.green     = canvas_green;
    c1_next.blue      = canvas_blue;
  end

  always_comb begin
    pick_x  = map_pick(px2, w_sat);
    pick_y  = map_pick(py2, h_sat);
    x0_next = pick_x[COORD_W+7:8];
    y0_next = pick_y[COORD_W+7:8];
    x1_next = next_tap(x0_next, w_sat);
    y1_next = next_tap(y0_next, h_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
    end else if (adv) begin
      c1 <= c1_next;
      c2 <= c1;
      c3 <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1   <= dx_next;
      dy1   <= dy_next;
      idx1  <= texel_index;
      rgba1 <= texel_rgba;
      px2   <= dx1 * $signed({1'b0, cfg.step_horizontal});
      py2   <= dy1 * $signed({1'b0, cfg.step_vertical});
      idx2  <= idx1;
      rgba2 <= rgba1;
      x0    <= x0_next;
      y0    <= y0_next;
      x1    <= x1_next;
      y1    <= y1_next;
      fx    <= pick_x[7:0];
      fy    <= pick_y[7:0];
      idx3  <= idx2;
      rgba3 <= rgba2;
    end
  end
endmodule
`default_nettype wire

// ===== sv/bsab_filter.sv =====
// Texel store, four-tap fetch and bilinear filter, stages four to six.
`default_nettype none
module bsab_filter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire bsab_pkg::bsab_ctl_t         c3,
  input  wire logic [bsab_pkg::DIM_W-1:0]  w_sat,
  input  wire logic [bsab_pkg::COORD_W-1:0] x0,
  input  wire logic [bsab_pkg::COORD_W-1:0] x1,
  input  wire logic [bsab_pkg::COORD_W-1:0] y0,
  input  wire logic [bsab_pkg::COORD_W-1:0] y1,
  input  wire logic [7:0]                  fx,
  input  wire logic [7:0]                  fy,
  input  wire logic [11:0]                 idx3,
  input  wire logic [31:0]                 rgba3,
  output bsab_pkg::bsab_ctl_t              c6,
  output logic [3:0][23:0]                 samp6
);
  import bsab_pkg::*;

  bsab_ctl_t c4, c5;
  logic [7:0] fx4, fy4, fy5;
  logic we;
  logic [ADDR_W-1:0] waddr;
  logic [3:0][ADDR_W-1:0] raddr;
  logic [3:0][31:0] tex;
  logic [3:0][15:0] top_n, bot_n, top5, bot5;
  logic [3:0][23:0] samp_n;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [DIM_W-1:0] w);
    logic [MAC_W-1:0] a;
    a = MAC_W'(y) * MAC_W'(w) + MAC_W'(x);
    return a[ADDR_W-1:0];
  endfunction

  assign we       = adv && c3.valid && (c3.composite == OP_LOAD) &&
                    ({1'b0, idx3} < 13'(TEXEL_DEPTH));
  assign waddr    = ADDR_W'(idx3);
  assign raddr[0] = addr_of(x0, y0, w_sat);
  assign raddr[1] = addr_of(x1, y0, w_sat);
  assign raddr[2] = addr_of(x0, y1, w_sat);
  assign raddr[3] = addr_of(x1, y1, w_sat);

  for (genvar t = 0; t < 4; t++) begin : g_tap
    bsab_ram #(.WIDTH(32), .DEPTH(TEXEL_DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (rgba3),
      .re    (adv),
      .raddr (raddr[t]),
      .rdata (tex[t])
    );
  end

  always_comb begin
    logic [8:0] wx, wy;
    logic [16:0] pa, pb;
    logic [24:0] sa, sb;
    wx = 9'd256 - {1'b0, fx4};
    wy = 9'd256 - {1'b0, fy5};
    for (int c = 0; c < 4; c++) begin
      pa = 17'(tex[0][8*c +: 8]) * 17'(wx) + 17'(tex[1][8*c +: 8]) * 17'(fx4);
      pb = 17'(tex[2][8*c +: 8]) * 17'(wx) + 17'(tex[3][8*c +: 8]) * 17'(fx4);
      top_n[c] = pa[15:0];
      bot_n[c] = pb[15:0];
      sa = 25'(top5[c]) * 25'(wy) + 25'(bot5[c]) * 25'(fy5);
      sb = sa;
      samp_n[c] = sb[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (adv) begin
      c4 <= c3;
      c5 <= c4;
      c6 <= c5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fx4   <= fx;
      fy4   <= fy;
      fy5   <= fy4;
      top5  <= top_n;
      bot5  <= bot_n;
      samp6 <= samp_n;
    end
  end
endmodule
`default_nettype wire

// ===== sv/bsab_blend.sv =====
// Alpha test, blend products and divide by 255, stages seven to nine.
`default_nettype none
module bsab_blend (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire bsab_pkg::bsab_ctl_t c6,
  input  wire logic [3:0][23:0]    samp6,
  output logic                     out_valid,
  output logic [7:0]               out_red,
  output logic [7:0]               out_green,
  output logic [7:0]               out_blue,
  output logic                     blended
);
  import bsab_pkg::*;

  bsab_ctl_t c7, c8, c7_next;
  logic [2:0][47:0] t1, t1_next;
  logic [2:0][31:0] t2, t2_next;
  logic [2:0][16:0] n8, n_next;
  logic [2:0][9:0]  q8, q_next;
  logic [2:0][7:0]  r_next;
  logic [2:0][7:0]  canv6, canv8;
  logic alpha_ok;

  assign canv6 = {c6.blue, c6.green, c6.red};
  assign canv8 = {c8.blue, c8.green, c8.red};

  always_comb begin
    logic [48:0] sum;
    logic [25:0] scaled;
    logic [16:0] rem;
    alpha_ok = (32'(samp6[3]) * 32'd250) > 32'(ALPHA_FULL);
    c7_next     = c6;
    c7_next.hit = c6.hit && alpha_ok;
    for (int c = 0; c < 3; c++) begin
      t1_next[c] = 48'(samp6[c]) * 48'(samp6[3]);
      t2_next[c] = 32'(canv6[c]) * 32'(ALPHA_FULL - samp6[3]);
      sum        = 49'(t1[c]) + {1'b0, t2[c], 16'h0000};
      n_next[c]  = sum[48:32];
      scaled     = 26'(n_next[c]) * 26'd257;
      q_next[c]  = scaled[25:16];
      rem        = n8[c] - 17'(q8[c]) * 17'd255;
      r_next[c]  = (rem >= 17'd255) ? 8'(q8[c] + 10'd1) : 8'(q8[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c7        <= '0;
      c8        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      c7        <= c7_next;
      c8        <= c7;
      out_valid <= c8.valid && (c8.composite == OP_COMPOSITE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1        <= t1_next;
      t2        <= t2_next;
      n8        <= n_next;
      q8        <= q_next;
      out_red   <= c8.hit ? r_next[0] : canv8[0];
      out_green <= c8.hit ? r_next[1] : canv8[1];
      out_blue  <= c8.hit ? r_next[2] : canv8[2];
      blended   <= c8.hit;
    end
  end
endmodule
`default_nettype wire

// ===== sv/bilinear_sprite_alpha_blit.sv =====
// Top level: configuration registers, pipeline control and the three pipeline sections.
// A composite transaction passes through 9 stages from the edge that accepts it to its result.
// Throughput: one transaction per cycle; a stalled result freezes the whole pipeline.
// Load transactions write the texel store in stage four and give no result.
// Reset clears the configuration registers and all stage valid bits.
// The texel store is not cleared and holds no valid bits.
`default_nettype none
module bilinear_sprite_alpha_blit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [11:0] texel_index,
  input  wire logic [31:0] texel_rgba,
  input  wire logic [11:0] pixel_x,
  input  wire logic [11:0] pixel_y,
  input  wire logic [7:0]  canvas_red,
  input  wire logic [7:0]  canvas_green,
  input  wire logic [7:0]  canvas_blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             blended,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import bsab_pkg::*;

  bsab_cfg_t cfg;
  bsab_ctl_t c3, c6;
  logic adv, take;
  logic [DIM_W-1:0] w_sat, h_sat;
  logic [COORD_W-1:0] x0, x1, y0, y1;
  logic [7:0] fx, fy;
  logic [11:0] idx3;
  logic [31:0] rgba3;
  logic [3:0][23:0] samp6;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign take      = in_valid && adv;
  assign cfg_ready = 1'b1;
  assign w_sat = (cfg.sprite_width > DIM_W'(SPRITE_SIDE)) ? DIM_W'(SPRITE_SIDE) :
                 cfg.sprite_width;
  assign h_sat = (cfg.sprite_height > DIM_W'(SPRITE_SIDE)) ? DIM_W'(SPRITE_SIDE) :
                 cfg.sprite_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SPRITE_WIDTH:  cfg.sprite_width    <= cfg_data[DIM_W-1:0];
        REG_SPRITE_HEIGHT: cfg.sprite_height   <= cfg_data[DIM_W-1:0];
        REG_RECT_LEFT:     cfg.rect_left       <= $signed(cfg_data[21:0]);
        REG_RECT_TOP:      cfg.rect_top        <= $signed(cfg_data[21:0]);
        REG_RECT_WIDTH:    cfg.rect_width      <= cfg_data[20:0];
        REG_RECT_HEIGHT:   cfg.rect_height     <= cfg_data[20:0];
        REG_STEP_H:        cfg.step_horizontal <= cfg_data;
        REG_STEP_V:        cfg.step_vertical   <= cfg_data;
      endcase
    end
  end

  bsab_map u_map (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .take         (take),
    .cfg          (cfg),
    .w_sat        (w_sat),
    .h_sat        (h_sat),
    .operation    (operation),
    .texel_index  (texel_index),
    .texel_rgba   (texel_rgba),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .canvas_red   (canvas_red),
    .canvas_green (canvas_green),
    .canvas_blue  (canvas_blue),
    .c3           (c3),
    .x0           (x0),
    .x1           (x1),
    .y0           (y0),
    .y1           (y1),
    .fx           (fx),
    .fy           (fy),
    .idx3         (idx3),
    .rgba3        (rgba3)
  );

  bsab_filter u_filter (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .c3    (c3),
    .w_sat (w_sat),
    .x0    (x0),
    .x1    (x1),
    .y0    (y0),
    .y1    (y1),
    .fx    (fx),
    .fy    (fy),
    .idx3  (idx3),
    .rgba3 (rgba3),
    .c6    (c6),
    .samp6 (samp6)
  );

  bsab_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .c6        (c6),
    .samp6     (samp6),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .blended   (blended)
  );

  a_blend_needs_sprite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && blended) |-> (w_sat != '0 && h_sat != '0 &&
                                cfg.rect_width != '0 && cfg.rect_height != '0))
    else $error("blended result with sprite or rectangle disabled");

  a_reset_flushes: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (c6.valid && c6.composite == OP_LOAD && !out_stall) |-> ##3 !out_valid || $past(!adv, 1)
    || $past(!adv, 2) || $past(!adv, 3))
    else $error("load transaction produced a result");
endmodule
`default_nettype wire

// ===== sim/bilinear_sprite_alpha_blit_tb.sv =====
// Self-checking testbench for the scaled sprite compositor: directed and random traffic.
`default_nettype none
module bilinear_sprite_alpha_blit_tb;
  import bsab_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_LOAD;
  logic [11:0] texel_index = '0;
  logic [31:0] texel_rgba = '0;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic [7:0]  canvas_red = '0;
  logic [7:0]  canvas_green = '0;
  logic [7:0]  canvas_blue = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        blended;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       bl;
  } pixel_res_t;

  pixel_res_t pixel_q[$];
  logic [31:0] texel_mem [TEXEL_DEPTH];
  bsab_cfg_t cfg_m;
  int errors = 0;
  longint cycles = 0;
  bit rx_random = 1'b1;
  int rx_wait = 0;

  always #2 clk = ~clk;

  bilinear_sprite_alpha_blit dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic is_covered(logic [11:0] p, logic signed [21:0] edge_q,
                                      logic [20:0] size);
    longint p256;
    p256 = longint'(p) * 256;
    return (p256 + 256 > longint'(edge_q)) && (p256 < longint'(edge_q) + longint'(size));
  endfunction

  function automatic int axis_map(logic [11:0] p, logic signed [21:0] edge_q,
                                  logic [23:0] step, int dim, output int frac);
    longint d, u, hi;
    d = longint'(p) * 256 + 128 - longint'(edge_q);
    u = d * longint'(step) - (longint'(1) << 23);
    hi = longint'(dim - 1) << 24;
    if (u < 0) u = 0;
    if (u > hi) u = hi;
    frac = int'((u >> 16) & 8'hFF);
    return int'(u >> 24);
  endfunction

  function automatic pixel_res_t composite_pixel(logic [11:0] x, logic [11:0] y,
                                                 logic [7:0] cr, logic [7:0] cg,
                                                 logic [7:0] cb);
    pixel_res_t res;
    int w, h, fx, fy, x0, y0, x1, y1;
    logic [31:0] t [4];
    longint unsigned s [4];
    longint unsigned cv [3];
    longint unsigned p00, p10, p01, p11, top, bot, num, q;
    res = '{r: cr, g: cg, b: cb, bl: 1'b0};
    cv[0] = cr; cv[1] = cg; cv[2] = cb;
    w = (cfg_m.sprite_width > SPRITE_SIDE) ? SPRITE_SIDE : int'(cfg_m.sprite_width);
    h = (cfg_m.sprite_height > SPRITE_SIDE) ? SPRITE_SIDE : int'(cfg_m.sprite_height);
    if (w == 0 || h == 0 || cfg_m.rect_width == 0 || cfg_m.rect_height == 0) return res;
    if (!is_covered(x, cfg_m.rect_left, cfg_m.rect_width) ||
        !is_covered(y, cfg_m.rect_top, cfg_m.rect_height)) return res;
    x0 = axis_map(x, cfg_m.rect_left, cfg_m.step_horizontal, w, fx);
    y0 = axis_map(y, cfg_m.rect_top, cfg_m.step_vertical, h, fy);
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    t[0] = texel_mem[y0 * w + x0];
    t[1] = texel_mem[y0 * w + x1];
    t[2] = texel_mem[y1 * w + x0];
    t[3] = texel_mem[y1 * w + x1];
    for (int c = 0; c < 4; c++) begin
      p00 = t[0][8*c +: 8]; p10 = t[1][8*c +: 8];
      p01 = t[2][8*c +: 8]; p11 = t[3][8*c +: 8];
      top = p00 * (256 - fx) + p10 * fx;
      bot = p01 * (256 - fx) + p11 * fx;
      s[c] = top * (256 - fy) + bot * fy;
    end
    if (s[3] * 250 <= 64'd255 * 65536) return res;
    for (int c = 0; c < 3; c++) begin
      num = s[c] * s[3] + cv[c] * (64'd255 * 65536 - s[3]) * 65536;
      q = num / (64'd255 << 32);
      if (q > 255) q = 255;
      cv[c] = q;
    end
    res = '{r: cv[0][7:0], g: cv[1][7:0], b: cv[2][7:0], bl: 1'b1};
    return res;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    pixel_res_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{r: out_red, g: out_green, b: out_blue, bl: blended};
      if (pixel_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.r != want.r) begin
          $display("%0t red exp %0d got %0d", $time, want.r, got.r); errors++;
        end
        if (got.g != want.g) begin
          $display("%0t green exp %0d got %0d", $time, want.g, got.g); errors++;
        end
        if (got.b != want.b) begin
          $display("%0t blue exp %0d got %0d", $time, want.b, got.b); errors++;
        end
        if (got.bl != want.bl) begin
          $display("%0t blended exp %0d got %0d", $time, want.bl, got.bl); errors++;
        end
      end
      rx_wait = rx_random ? $urandom_range(0, 6) : 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  task automatic send_item(logic op, logic [11:0] idx, logic [31:0] rgba, logic [11:0] x,
                           logic [11:0] y, logic [7:0] cr, logic [7:0] cg, logic [7:0] cb,
                           bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    operation <= op; texel_index <= idx; texel_rgba <= rgba;
    pixel_x <= x; pixel_y <= y;
    canvas_red <= cr; canvas_green <= cg; canvas_blue <= cb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) begin
      if (idx < TEXEL_DEPTH) texel_mem[idx] = rgba;
    end else begin
      pixel_q.push_back(composite_pixel(x, y, cr, cg, cb));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SPRITE_WIDTH:  cfg_m.sprite_width = val[6:0];
      REG_SPRITE_HEIGHT: cfg_m.sprite_height = val[6:0];
      REG_RECT_LEFT:     cfg_m.rect_left = val[21:0];
      REG_RECT_TOP:      cfg_m.rect_top = val[21:0];
      REG_RECT_WIDTH:    cfg_m.rect_width = val[20:0];
      REG_RECT_HEIGHT:   cfg_m.rect_height = val[20:0];
      REG_STEP_H:        cfg_m.step_horizontal = val;
      default:           cfg_m.step_vertical = val;
    endcase
  endtask

  task automatic set_blit(int sw, int sh, int left, int top, int rw, int rh, int stx, int sty);
    write_reg(REG_SPRITE_WIDTH, sw);
    write_reg(REG_SPRITE_HEIGHT, sh);
    write_reg(REG_RECT_LEFT, left);
    write_reg(REG_RECT_TOP, top);
    write_reg(REG_RECT_WIDTH, rw);
    write_reg(REG_RECT_HEIGHT, rh);
    write_reg(REG_STEP_H, stx);
    write_reg(REG_STEP_V, sty);
  endtask

  // writes every texel the current sprite size can touch
  task automatic fill_sprite(int w, int h, bit opaque_bias);
    logic [31:0] v;
    for (int i = 0; i < w * h; i++) begin
      v = $urandom();
      if (opaque_bias && $urandom_range(0, 3) != 0) v[31:24] = 8'hF0 | v[27:24];
      send_item(OP_LOAD, i, v, '0, '0, '0, '0, '0, $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic random_pixel(int span);
    send_item(OP_COMPOSITE, $urandom(), $urandom(),
              (span == 0) ? 12'($urandom()) : 12'($urandom_range(0, span)),
              (span == 0) ? 12'($urandom()) : 12'($urandom_range(0, span)),
              $urandom(), $urandom(), $urandom());
  endtask

  task automatic test_disabled();
    // registers at reset: everything passes unchanged
    send_item(OP_COMPOSITE, 0, 0, 0, 0, 8'h00, 8'hFF, 8'h5A);
    send_item(OP_COMPOSITE, 0, 0, 12'hFFF, 12'hFFF, 8'hFF, 8'h00, 8'hA5);
    drain();
  endtask

  task automatic test_directed();
    send_item(OP_LOAD, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0);
    send_item(OP_LOAD, 1, 32'h00000000, 0, 0, 0, 0, 0);
    send_item(OP_LOAD, 2, 32'h01FF00FF, 0, 0, 0, 0, 0);
    send_item(OP_LOAD, 3, 32'h80123456, 0, 0, 0, 0, 0);
    send_item(OP_LOAD, 12'hFFF, 32'hA5A5A5A5, 0, 0, 0, 0, 0);
    drain();
    // 2x2 sprite onto an 8x8 rectangle at (4,4), step 0.25
    set_blit(2, 2, 4 * 256, 4 * 256, 8 * 256, 8 * 256, 24'h4000, 24'h4000);
    send_item(OP_COMPOSITE, 0, 0, 4, 4, 8'h00, 8'h00, 8'h00);
    send_item(OP_COMPOSITE, 0, 0, 11, 11, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_COMPOSITE, 0, 0, 7, 8, 8'h10, 8'h20, 8'h30);
    send_item(OP_COMPOSITE, 0, 0, 3, 5, 8'h11, 8'h22, 8'h33);
    send_item(OP_COMPOSITE, 0, 0, 12, 5, 8'h11, 8'h22, 8'h33);
    send_item(OP_COMPOSITE, 0, 0, 5, 12, 8'h11, 8'h22, 8'h33);
    drain();
    // zero sizes disable
    write_reg(REG_RECT_WIDTH, 0);
    send_item(OP_COMPOSITE, 0, 0, 5, 5, 8'h44, 8'h55, 8'h66);
    drain();
    write_reg(REG_RECT_WIDTH, 8 * 256);
    write_reg(REG_SPRITE_HEIGHT, 0);
    send_item(OP_COMPOSITE, 0, 0, 5, 5, 8'h44, 8'h55, 8'h66);
    drain();
    // oversized sprite saturates; the clamped corner texel is the only one read
    send_item(OP_LOAD, 12'hFFF, 32'hF0C08040, 0, 0, 0, 0, 0);
    drain();
    set_blit(127, 127, 24'h200000, 24'h200000, 24'h1FFFFF, 24'h1FFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_COMPOSITE, 0, 0, 0, 0, 8'h01, 8'h02, 8'h03);
    send_item(OP_COMPOSITE, 0, 0, 12'hFFF, 12'hFFF, 8'hFE, 8'hFD, 8'hFC);
    drain();
    set_blit(64, 64, 24'h1FFFFF, 0, 24'h1FFFFF, 24'h1FFFFF, 0, 0);
    send_item(OP_COMPOSITE, 0, 0, 12'hFFF, 0, 8'h80, 8'h80, 8'h80);
    send_item(OP_COMPOSITE, 0, 0, 0, 0, 8'h80, 8'h80, 8'h80);
    drain();
    set_blit(64, 64, 0, 0, 24'h1FFFFF, 24'h1FFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_COMPOSITE, 0, 0, 0, 0, 8'h80, 8'h80, 8'h80);
    send_item(OP_COMPOSITE, 0, 0, 12'h7FF, 12'h800, 8'h7F, 8'h80, 8'h81);
    drain();
  endtask

  task automatic test_random();
    int sw, sh, rw, rh;
    for (int ph = 0; ph < 12; ph++) begin
      rx_random = (ph % 4 != 3);
      sw = (ph % 3 == 0) ? $urandom_range(1, 3) : $urandom_range(1, 10);
      sh = (ph % 3 == 1) ? $urandom_range(1, 3) : $urandom_range(1, 10);
      if (ph == 5) begin sw = 64; sh = 1; end
      if (ph == 6) begin sw = 1; sh = 64; end
      rw = $urandom_range(1, 40) * 256 + $urandom_range(0, 255);
      rh = $urandom_range(1, 40) * 256 + $urandom_range(0, 255);
      set_blit(sw, sh, int'($urandom_range(0, 20 * 256)) - 2560,
               int'($urandom_range(0, 20 * 256)) - 2560, rw, rh,
               (sw * 65536 * 256) / rw + $urandom_range(0, 3000),
               (sh * 65536 * 256) / rh + $urandom_range(0, 3000));
      fill_sprite(sw, sh, ph % 2);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 9) == 0) random_pixel(0);
        else if ($urandom_range(0, 14) == 0)
          send_item(OP_LOAD, $urandom_range(0, sw * sh - 1), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom());
        else random_pixel(60);
      end
      drain();
    end
    rx_random = 1'b1;
  endtask

  initial begin
    cfg_m = '0;
    foreach (texel_mem[i]) texel_mem[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled();
    test_directed();
    test_random();
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
